// File: rtl/core/trr_pkg.sv
`default_nettype none

package trr_pkg;

   // Field widths.
   localparam int COORD_BITS  = 14;
   localparam int RADIUS_BITS = 12;
   localparam int OFS_W       = RADIUS_BITS + 1;
   localparam int PIX_W       = COORD_BITS + 1;
   localparam int DEC_W       = RADIUS_BITS + 6;
   localparam int CANVAS_W    = 13;

   // Midpoint decision constants.
   localparam int DEC_INIT    = 5;
   localparam int DEC_SCALE   = 8;
   localparam int DEC_BIAS    = 4;
   localparam int DEC_SHIFT   = $clog2(DEC_SCALE);
   localparam int INIT_SHIFT  = $clog2(DEC_BIAS);

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_FIELDS_W = 2 * COORD_BITS + 2 * RADIUS_BITS;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 2 * PIX_W + 1;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Command codes carried in req_tuser.
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   // Configuration register indexes.
   localparam logic REG_CANVAS_WIDTH  = 1'b0;
   localparam logic REG_CANVAS_HEIGHT = 1'b1;

   localparam logic [CANVAS_W-1:0] WIDTH_RESET  = CANVAS_W'(1024);
   localparam logic [CANVAS_W-1:0] HEIGHT_RESET = CANVAS_W'(768);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [RADIUS_BITS-1:0]       radius_type;
   typedef logic [OFS_W-1:0]             ofs_type;
   typedef logic signed [PIX_W-1:0]      pix_type;
   typedef logic signed [DEC_W-1:0]      dec_type;

   // Ring load request from the input channel to the walker.
   typedef struct packed {
      logic       valid;
      coord_type  center_x;
      coord_type  center_y;
      radius_type inner_radius;
      radius_type outer_radius;
   } start_type;

   // One pixel produced by the walker.
   typedef struct packed {
      logic    valid;
      pix_type x;
      pix_type y;
   } pixel_type;

endpackage

`default_nettype wire

// File: rtl/core/thick_circle_ring_rasterizer.sv
`default_nettype none

// Thick circle ring rasterizer.
//
// The req channel carries commands. A start transfer (req_tuser low) loads the
// ring center and the inner and outer radii and produces no result; any walk
// in progress is dropped. A step transfer (req_tuser high) produces exactly one
// rsp transfer: the next pixel of the ring, or an empty result (rsp_tuser high)
// when no walk is active. rsp_tlast marks the final pixel of a ring.
// The csr port writes the canvas width and height, which set the visible flag
// at the time a step is taken.
//
// A step result appears on rsp in the cycle after its req transfer. Steps are
// taken at one per cycle while the two-pixel look-ahead stays full and the
// output register is free or emptying. The walker resolves one column change
// together with its first pixel, so a column whose row range is empty costs
// a walker step, and after a start the look-ahead refills before any step.
//
// Reset clears the walk and restores the canvas size to 1024 by 768. When the
// receiver stalls, the result waits in the output register and req_tready
// stays high only if that result is taken in the same cycle.
module thick_circle_ring_rasterizer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // req_tdata, low bit up: center_x, center_y, inner_radius, outer_radius.
   input  wire logic [trr_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_tuser: command.
   input  wire logic                             req_tuser,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // rsp_tdata, low bit up: pixel_x, pixel_y, visible.
   output logic [trr_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // rsp_tuser: empty_res.
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   input  wire logic                             csr_write,
   input  wire logic                             csr_index,
   input  wire logic [trr_pkg::CANVAS_W-1:0]     csr_data
);

   localparam int CX_LO = 0;
   localparam int CY_LO = CX_LO + trr_pkg::COORD_BITS;
   localparam int R1_LO = CY_LO + trr_pkg::COORD_BITS;
   localparam int R2_LO = R1_LO + trr_pkg::RADIUS_BITS;
   localparam int CMP_W = trr_pkg::PIX_W + 1;

   logic [trr_pkg::CANVAS_W-1:0] width_ff, height_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   trr_pkg::pix_type    rsp_x_ff, rsp_x_in;
   trr_pkg::pix_type    rsp_y_ff, rsp_y_in;
   logic                rsp_vis_ff, rsp_vis_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_empty_ff, rsp_empty_in;

   trr_pkg::start_type  start;
   trr_pkg::pixel_type  push, head;
   logic [1:0]          count;
   logic                space, walk_on, settled, out_space;
   logic                req_fire, step_fire, pop;
   logic signed [CMP_W-1:0] x_cmp, y_cmp, w_lim, h_lim;
   logic                visible;

   // A req transfer may be taken once the pixel after the head is known, or the
   // walk has ended; the output register must be free or emptying.
   assign out_space  = !rsp_valid_ff || rsp_tready;
   assign settled    = (count == 2'd2) || !walk_on;
   assign req_tready = out_space && settled;
   assign req_fire   = req_tvalid && req_tready;
   assign step_fire  = req_fire && (req_tuser == trr_pkg::CMD_STEP);
   assign pop        = step_fire && (count != 2'd0);

   always_comb begin
      start              = '0;
      start.valid        = req_fire && (req_tuser == trr_pkg::CMD_START);
      start.center_x     = req_tdata[CX_LO +: trr_pkg::COORD_BITS];
      start.center_y     = req_tdata[CY_LO +: trr_pkg::COORD_BITS];
      start.inner_radius = req_tdata[R1_LO +: trr_pkg::RADIUS_BITS];
      start.outer_radius = req_tdata[R2_LO +: trr_pkg::RADIUS_BITS];
   end

   trr_walker u_walker (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .space   (space),
      .push    (push),
      .walk_on (walk_on)
   );

   trr_lookahead u_lookahead (
      .clock (clock),
      .reset (reset),
      .flush (start.valid),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .count (count),
      .space (space)
   );

   // Visible needs 0 <= x < width - 1 and the same for y against height.
   assign x_cmp   = CMP_W'(head.x);
   assign y_cmp   = CMP_W'(head.y);
   assign w_lim   = $signed(CMP_W'(width_ff)) - CMP_W'(1);
   assign h_lim   = $signed(CMP_W'(height_ff)) - CMP_W'(1);
   assign visible = !head.x[trr_pkg::PIX_W-1] && (x_cmp < w_lim)
                    && !head.y[trr_pkg::PIX_W-1] && (y_cmp < h_lim);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_vis_in   = rsp_vis_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      if (step_fire) begin
         rsp_valid_in = 1'b1;
         if (count == 2'd0) begin
            rsp_x_in     = '0;
            rsp_y_in     = '0;
            rsp_vis_in   = 1'b0;
            rsp_last_in  = 1'b0;
            rsp_empty_in = 1'b1;
         end else begin
            rsp_x_in     = head.x;
            rsp_y_in     = head.y;
            rsp_vis_in   = visible;
            // With one pixel left the walk has already ended.
            rsp_last_in  = count == 2'd1;
            rsp_empty_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         width_ff     <= trr_pkg::WIDTH_RESET;
         height_ff    <= trr_pkg::HEIGHT_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               trr_pkg::REG_CANVAS_WIDTH:  width_ff  <= csr_data;
               trr_pkg::REG_CANVAS_HEIGHT: height_ff <= csr_data;
               default: ;
            endcase
         end
      end
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_vis_ff   <= rsp_vis_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_empty_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = trr_pkg::RSP_DATA_W'({rsp_vis_ff, rsp_y_ff, rsp_x_ff});

   // An empty result never closes a ring and never marks a pixel visible.
   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> (!rsp_last_ff && !rsp_vis_ff))
      else $error("empty result carries pixel flags");

endmodule

`default_nettype wire

// File: rtl/core/trr_walker.sv
`default_nettype none

module trr_walker (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire trr_pkg::start_type  start,
   input  wire logic                space,
   output trr_pkg::pixel_type       push,
   output logic                     walk_on
);

   typedef struct packed {
      logic                walk_on;
      logic                side_neg;
      logic                row_neg;
      logic                part_t;
      trr_pkg::ofs_type    col;
      trr_pkg::ofs_type    inner_e;
      trr_pkg::ofs_type    outer_e;
      trr_pkg::ofs_type    row;
      trr_pkg::dec_type    inner_d;
      trr_pkg::dec_type    outer_d;
   } walk_state_type;

   walk_state_type     state_ff, state_in;
   trr_pkg::coord_type center_x_ff, center_x_in;
   trr_pkg::coord_type center_y_ff, center_y_in;

   walk_state_type s_skip, s_from;
   logic           need_skip, can_emit, go;

   function automatic logic dec_pos(trr_pkg::dec_type d);
      return !d[trr_pkg::DEC_W-1] && (d != '0);
   endfunction

   // Decision update for one column step; moved means the edge just dropped.
   function automatic trr_pkg::dec_type dec_step(trr_pkg::dec_type d, trr_pkg::ofs_type c,
                                                 trr_pkg::ofs_type e, logic moved);
      trr_pkg::dec_type delta;
      if (moved) begin
         delta = $signed(trr_pkg::DEC_W'(c)) - $signed(trr_pkg::DEC_W'(e));
      end else begin
         delta = $signed(trr_pkg::DEC_W'(c));
      end
      return d + (delta <<< trr_pkg::DEC_SHIFT) + trr_pkg::DEC_W'(trr_pkg::DEC_BIAS);
   endfunction

   function automatic walk_state_type skip_step(walk_state_type s);
      walk_state_type   t;
      trr_pkg::ofs_type c1;
      t  = s;
      c1 = s.col + 1'b1;
      if (!s.side_neg && (s.col != '0)) begin
         t.side_neg = 1'b1;
         t.row      = s.inner_e;
         t.row_neg  = 1'b0;
         t.part_t   = 1'b0;
      end else if (!(s.outer_e > s.col)) begin
         t.walk_on = 1'b0;
      end else begin
         t.col = c1;
         if (dec_pos(s.outer_d)) begin
            t.outer_e = s.outer_e - 1'b1;
            t.outer_d = dec_step(s.outer_d, c1, t.outer_e, 1'b1);
         end else begin
            t.outer_d = dec_step(s.outer_d, c1, s.outer_e, 1'b0);
         end
         if (s.inner_e < c1) begin
            t.inner_e = c1;
         end else if (dec_pos(s.inner_d)) begin
            t.inner_e = s.inner_e - 1'b1;
            t.inner_d = dec_step(s.inner_d, c1, t.inner_e, 1'b1);
         end else begin
            t.inner_d = dec_step(s.inner_d, c1, s.inner_e, 1'b0);
         end
         t.side_neg = 1'b0;
         t.row      = t.inner_e;
         t.row_neg  = 1'b0;
         t.part_t   = 1'b0;
      end
      return t;
   endfunction

   function automatic walk_state_type next_row(walk_state_type s);
      walk_state_type t;
      t        = s;
      t.part_t = 1'b0;
      if (!s.row_neg && (s.row != '0)) begin
         t.row_neg = 1'b1;
      end else begin
         t.row_neg = 1'b0;
         t.row     = s.row + 1'b1;
      end
      return t;
   endfunction

   function automatic walk_state_type emit_advance(walk_state_type s);
      walk_state_type t;
      t = s;
      if (!s.part_t && (s.col != s.row)) begin
         t.part_t = 1'b1;
      end else begin
         t = next_row(s);
      end
      return t;
   endfunction

   function automatic trr_pkg::pix_type offset_add(trr_pkg::coord_type base,
                                                   trr_pkg::ofs_type ofs, logic neg);
      trr_pkg::pix_type b, d;
      b = trr_pkg::PIX_W'(base);
      d = $signed(trr_pkg::PIX_W'(ofs));
      if (neg) begin
         d = -d;
      end
      return b + d;
   endfunction

   assign need_skip = state_ff.row > state_ff.outer_e;
   assign s_skip    = skip_step(state_ff);
   assign s_from    = need_skip ? s_skip : state_ff;
   assign can_emit  = s_from.walk_on && (s_from.row <= s_from.outer_e);
   assign go        = state_ff.walk_on && space && !start.valid;

   always_comb begin
      state_in    = state_ff;
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      push        = '0;
      if (start.valid) begin
         center_x_in      = start.center_x;
         center_y_in      = start.center_y;
         state_in         = '0;
         state_in.walk_on = 1'b1;
         state_in.inner_e = trr_pkg::OFS_W'(start.inner_radius);
         state_in.outer_e = trr_pkg::OFS_W'(start.outer_radius);
         state_in.row     = trr_pkg::OFS_W'(start.inner_radius);
         state_in.inner_d = trr_pkg::DEC_W'(trr_pkg::DEC_INIT)
                            - (trr_pkg::DEC_W'(start.inner_radius) <<< trr_pkg::INIT_SHIFT);
         state_in.outer_d = trr_pkg::DEC_W'(trr_pkg::DEC_INIT)
                            - (trr_pkg::DEC_W'(start.outer_radius) <<< trr_pkg::INIT_SHIFT);
      end else if (go) begin
         if (can_emit) begin
            push.valid = 1'b1;
            if (!s_from.part_t) begin
               push.x = offset_add(center_x_ff, s_from.col, s_from.side_neg);
               push.y = offset_add(center_y_ff, s_from.row, s_from.row_neg);
            end else begin
               push.x = offset_add(center_x_ff, s_from.row, s_from.row_neg);
               push.y = offset_add(center_y_ff, s_from.col, s_from.side_neg);
            end
            state_in = emit_advance(s_from);
         end else begin
            state_in = s_from;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
      center_x_ff <= center_x_in;
      center_y_ff <= center_y_in;
   end

   assign walk_on = state_ff.walk_on;

   // A pixel only comes out of an active walk with room to take it.
   a_push_needs_walk: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (state_ff.walk_on && space && !start.valid))
      else $error("walker pushed a pixel outside an active walk");

   // A start always leaves a fresh walk at column zero.
   a_start_loads: assert property (@(posedge clock) disable iff (reset)
      start.valid |=> (state_ff.walk_on && (state_ff.col == '0) && !state_ff.side_neg))
      else $error("start did not load a fresh walk");

endmodule

`default_nettype wire

// File: rtl/core/trr_lookahead.sv
`default_nettype none

module trr_lookahead (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                flush,
   input  wire trr_pkg::pixel_type  push,
   input  wire logic                pop,
   output trr_pkg::pixel_type       head,
   output logic [1:0]               count,
   output logic                     space
);

   trr_pkg::pixel_type entry0_ff, entry0_in;
   trr_pkg::pixel_type entry1_ff, entry1_in;
   logic [1:0]         count_ff, count_in;
   logic [1:0]         count_after;

   assign count_after = count_ff - 2'(pop);
   assign space       = count_after != 2'd2;

   always_comb begin
      entry0_in = entry0_ff;
      entry1_in = entry1_ff;
      count_in  = count_after + 2'(push.valid);
      if (pop) begin
         entry0_in = entry1_ff;
      end
      if (push.valid) begin
         if (count_after == 2'd0) begin
            entry0_in = push;
         end else begin
            entry1_in = push;
         end
      end
      if (flush) begin
         count_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      entry0_ff <= entry0_in;
      entry1_ff <= entry1_in;
   end

   assign head  = entry0_ff;
   assign count = count_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("look-ahead count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push.valid && (count_ff == 2'd2)) |-> pop)
      else $error("pixel pushed into a full look-ahead");

endmodule

`default_nettype wire
